// ===== rtl/homogeneous_point_transform_top_assert.svh =====
// Assertion macros for the homogeneous point transform.
// Used by the port checker; depends on nothing else.
`ifndef HOMOGENEOUS_POINT_TRANSFORM_TOP_ASSERT_SVH
`define HOMOGENEOUS_POINT_TRANSFORM_TOP_ASSERT_SVH

// Same-cycle implication under reset.
`define HPT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hpt check failed");

// Next-cycle implication under reset.
`define HPT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hpt check failed");

`endif

// ===== rtl/hpt_pkg.sv =====
// Shared types, constants and the divider step for the point transform.
// No dependencies.
package hpt_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int HW            = 58;
    localparam int MW            = 58;
    localparam int QW            = 32;
    localparam int STEPS         = 2;
    localparam int DIV_STAGES    = QW / STEPS;
    localparam int NUM_REGS      = 8;

    localparam logic [NUM_REGS-1:0][63:0] CFG_RESET = {
        64'h0001_0000_0000_0000,
        64'h0,
        64'h0000_0000_0001_0000,
        64'h0,
        64'h0,
        64'h0001_0000_0000_0000,
        64'h0,
        64'h0000_0000_0001_0000
    };

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_WZERO = 2'd1,
        ST_SAT   = 2'd2
    } status_t;

    typedef struct packed {
        logic signed [31:0] in_x;
        logic signed [31:0] in_y;
        logic signed [31:0] in_z;
    } point_t;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        status_t            status;
    } result_t;

    typedef logic [3:0][3:0][31:0] mat_t;

    typedef struct packed {
        logic               valid;
        logic [3:0][HW-1:0] h;
    } mac_out_t;

    typedef struct packed {
        logic               valid;
        logic               wzero;
        logic [2:0]         neg;
        logic [2:0]         ovf;
        logic [2:0][QW-1:0] mag;
    } div_out_t;

    typedef struct packed {
        logic [MW-1:0] rem;
        logic [MW-1:0] den;
        logic [QW-1:0] nlow;
        logic [QW-1:0] quo;
        logic          neg;
        logic          ovf;
    } div_lane_t;

    // One restoring division step: bring down the next dividend bit.
    function automatic div_lane_t div_step(input div_lane_t l);
        logic [MW:0] trial;
        logic [MW:0] diff;
        div_lane_t   r;
        r      = l;
        trial  = {l.rem, l.nlow[QW-1]};
        diff   = trial - {1'b0, l.den};
        r.nlow = {l.nlow[QW-2:0], 1'b0};
        if (trial >= {1'b0, l.den})
        begin
            r.rem = diff[MW-1:0];
            r.quo = {l.quo[QW-2:0], 1'b1};
        end
        else
        begin
            r.rem = trial[MW-1:0];
            r.quo = {l.quo[QW-2:0], 1'b0};
        end
        return r;
    endfunction

endpackage

// ===== rtl/hpt_mac.sv =====
// Matrix multiply stages: twelve products, then a two-level adder tree.
// Depends on hpt_pkg.
module hpt_mac #(
    parameter int FRAC_BITS = hpt_pkg::FRAC_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  hpt_pkg::point_t   pt,
    input  hpt_pkg::mat_t     mat,
    output hpt_pkg::mac_out_t mac_out
);
    import hpt_pkg::*;

    logic signed [31:0]   coord [3];
    logic signed [63:0]   prod_next [3][4];
    logic signed [63:0]   prod_reg  [3][4];
    logic                 valid1_reg;
    logic signed [HW-1:0] part_a_next [4];
    logic signed [HW-1:0] part_b_next [4];
    logic signed [HW-1:0] part_a_reg  [4];
    logic signed [HW-1:0] part_b_reg  [4];
    logic                 valid2_reg;
    logic [3:0][HW-1:0]   h_reg;
    logic                 valid3_reg;

    assign coord[0] = pt.in_x;
    assign coord[1] = pt.in_y;
    assign coord[2] = pt.in_z;

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 4; c++)
            begin
                prod_next[r][c] = coord[r] * $signed(mat[r][c]);
            end
        end
        for (int c = 0; c < 4; c++)
        begin
            // Arithmetic shift gives the floor of each scaled product.
            part_a_next[c] = HW'(prod_reg[0][c] >>> FRAC_BITS)
                           + HW'(prod_reg[1][c] >>> FRAC_BITS);
            part_b_next[c] = HW'(prod_reg[2][c] >>> FRAC_BITS)
                           + HW'($signed(mat[3][c]));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid1_reg <= 1'b0;
            valid2_reg <= 1'b0;
            valid3_reg <= 1'b0;
        end
        else if (en)
        begin
            valid1_reg <= in_valid;
            valid2_reg <= valid1_reg;
            valid3_reg <= valid2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg   <= prod_next;
            part_a_reg <= part_a_next;
            part_b_reg <= part_b_next;
            for (int c = 0; c < 4; c++)
            begin
                h_reg[c] <= part_a_reg[c] + part_b_reg[c];
            end
        end
    end

    assign mac_out.valid = valid3_reg;
    assign mac_out.h     = h_reg;

endmodule

// ===== rtl/hpt_div.sv =====
// Pipelined restoring divider, three lanes sharing the divisor w.
// Depends on hpt_pkg.
module hpt_div #(
    parameter int FRAC_BITS = hpt_pkg::FRAC_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  hpt_pkg::mac_out_t mac_out,
    output hpt_pkg::div_out_t div_out
);
    import hpt_pkg::*;

    localparam int NW = MW + FRAC_BITS;

    logic [MW-1:0]   num_abs_reg [3];
    logic [MW-1:0]   den_abs_reg;
    logic [2:0]      neg_reg;
    logic            wza_reg;
    logic            va_reg;
    logic [HW-1:0]   den_s;
    div_lane_t       init_lane [3];
    div_lane_t       lane_reg [DIV_STAGES+1][3];
    logic            valid_reg [DIV_STAGES+1];
    logic            wzero_reg [DIV_STAGES+1];

    assign den_s = mac_out.h[3];

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            logic [NW-1:0] nfull;
            nfull = {num_abs_reg[c], {FRAC_BITS{1'b0}}};
            init_lane[c].den  = den_abs_reg;
            init_lane[c].neg  = neg_reg[c];
            init_lane[c].ovf  = (MW+QW)'(nfull) >= {den_abs_reg, {QW{1'b0}}};
            init_lane[c].rem  = MW'(nfull >> QW);
            init_lane[c].nlow = nfull[QW-1:0];
            init_lane[c].quo  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            for (int k = 0; k <= DIV_STAGES; k++)
            begin
                valid_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            va_reg       <= mac_out.valid;
            valid_reg[0] <= va_reg;
            for (int k = 0; k < DIV_STAGES; k++)
            begin
                valid_reg[k+1] <= valid_reg[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int c = 0; c < 3; c++)
            begin
                num_abs_reg[c] <= mac_out.h[c][HW-1] ? MW'(-mac_out.h[c]) : MW'(mac_out.h[c]);
                neg_reg[c]     <= mac_out.h[c][HW-1] ^ den_s[HW-1];
                lane_reg[0][c] <= init_lane[c];
            end
            den_abs_reg  <= den_s[HW-1] ? MW'(-den_s) : MW'(den_s);
            wza_reg      <= (den_s == '0);
            wzero_reg[0] <= wza_reg;
            for (int k = 0; k < DIV_STAGES; k++)
            begin
                wzero_reg[k+1] <= wzero_reg[k];
                for (int c = 0; c < 3; c++)
                begin
                    lane_reg[k+1][c] <= div_step(div_step(lane_reg[k][c]));
                end
            end
        end
    end

    always_comb
    begin
        div_out.valid = valid_reg[DIV_STAGES];
        div_out.wzero = wzero_reg[DIV_STAGES];
        for (int c = 0; c < 3; c++)
        begin
            div_out.neg[c] = lane_reg[DIV_STAGES][c].neg;
            div_out.ovf[c] = lane_reg[DIV_STAGES][c].ovf;
            div_out.mag[c] = lane_reg[DIV_STAGES][c].quo;
        end
    end

endmodule

// ===== rtl/homogeneous_point_transform_top.sv =====
// Top level of the homogeneous point transform: matrix registers, the multiply
// and divide pipelines and the output register. Depends on hpt_pkg, hpt_mac and hpt_div.

// Each item is a point (x, y, z) in signed fixed point, taken as the row
// vector (x, y, z, 1) and multiplied by the 4x4 matrix held in the eight
// configuration registers; x, y and z of the product are then divided by w.
// The block takes one item every cycle unless stalled; each item passes
// through the multiplies and adder tree, the registers that take magnitudes
// and check for overflow, the divider (two quotient bits per stage over 32
// bits) and the output register. The whole pipeline advances together and
// halts only while a finished result waits under stall; a w of zero gives
// zero coordinates and status 1, a quotient that overflows saturates and
// gives status 2. The matrix is to be written only while no item is in
// flight.
module homogeneous_point_transform_top #(
    parameter int FRAC_BITS = hpt_pkg::FRAC_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             point_valid,
    output logic             point_stall,
    input  hpt_pkg::point_t  point,
    output logic             result_valid,
    input  logic             result_stall,
    output hpt_pkg::result_t result,
    input  logic             cfg_wr_en,
    input  logic [2:0]       cfg_index,
    input  logic [63:0]      cfg_data
);
    import hpt_pkg::*;

    logic [NUM_REGS-1:0][63:0] cfg_reg;
    mat_t                      mat;
    logic                      en;
    mac_out_t                  mac_out;
    div_out_t                  div_out;
    result_t                   result_next;
    result_t                   result_reg;
    logic                      result_valid_reg;
    logic [2:0]                sat;
    logic [2:0][31:0]          coord_out;

    // The matrix registers; each holds two columns of one row.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (cfg_wr_en)
        begin
            cfg_reg[cfg_index] <= cfg_data;
        end
    end

    always_comb
    begin
        for (int r = 0; r < 4; r++)
        begin
            for (int c = 0; c < 4; c++)
            begin
                mat[r][c] = cfg_reg[r*2 + c/2][(c%2)*32 +: 32];
            end
        end
    end

    // Every stage moves on unless the output holds a result that is stalled.
    assign en          = !result_valid_reg || !result_stall;
    assign point_stall = !en;

    hpt_mac #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mac (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (point_valid),
        .pt       (point),
        .mat      (mat),
        .mac_out  (mac_out)
    );

    hpt_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .mac_out (mac_out),
        .div_out (div_out)
    );

    // Sign restoration and saturation of the three quotients.
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            sat[c]       = 1'b0;
            coord_out[c] = div_out.mag[c];
            if (div_out.ovf[c])
            begin
                sat[c]       = 1'b1;
                coord_out[c] = div_out.neg[c] ? 32'h8000_0000 : 32'h7FFF_FFFF;
            end
            else if (div_out.neg[c])
            begin
                if (div_out.mag[c] > 32'h8000_0000)
                begin
                    sat[c]       = 1'b1;
                    coord_out[c] = 32'h8000_0000;
                end
                else
                begin
                    coord_out[c] = -div_out.mag[c];
                end
            end
            else if (div_out.mag[c] > 32'h7FFF_FFFF)
            begin
                sat[c]       = 1'b1;
                coord_out[c] = 32'h7FFF_FFFF;
            end
        end
        if (div_out.wzero)
        begin
            result_next.out_x  = '0;
            result_next.out_y  = '0;
            result_next.out_z  = '0;
            result_next.status = ST_WZERO;
        end
        else
        begin
            result_next.out_x  = coord_out[0];
            result_next.out_y  = coord_out[1];
            result_next.out_z  = coord_out[2];
            result_next.status = (|sat) ? ST_SAT : ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            result_valid_reg <= div_out.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// ===== rtl/hpt_checker.sv =====
// Port checker for the homogeneous point transform, bound to the top level.
// Depends on hpt_pkg and the assertion macro header.
`include "homogeneous_point_transform_top_assert.svh"

module hpt_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             point_stall,
    input logic             result_valid,
    input logic             result_stall,
    input hpt_pkg::result_t result
);
    import hpt_pkg::*;

    logic coords_zero;
    logic status_known;

    assign coords_zero  = (result.out_x == '0) && (result.out_y == '0) && (result.out_z == '0);
    assign status_known = (result.status == ST_OK) || (result.status == ST_WZERO)
                       || (result.status == ST_SAT);

    `HPT_ASSERT_NOW(a_status_code, clk, rst_n, result_valid, status_known)
    `HPT_ASSERT_NOW(a_wzero_zero, clk, rst_n, result_valid && result.status == ST_WZERO, coords_zero)
    `HPT_ASSERT_NOW(a_backpressure, clk, rst_n, result_valid && result_stall, point_stall)
    `HPT_ASSERT_NEXT(a_result_held, clk, rst_n, result_valid && result_stall, result_valid && $stable(result))

endmodule

bind homogeneous_point_transform_top hpt_checker u_hpt_checker (.*);

// ===== verif/tb_homogeneous_point_transform_top.sv =====
// Testbench for the homogeneous point transform: a self-checking run of points
// through the 4x4 matrix and perspective divide. Depends on hpt_pkg and the top.
`timescale 1ns / 1ps

module tb_homogeneous_point_transform_top;
    import hpt_pkg::*;

    localparam int FB          = 16;
    localparam int LATENCY     = 23;
    localparam int CYCLE_LIMIT = 400000;

    logic        clk;
    logic        rst_n;
    logic        point_valid;
    logic        point_stall;
    point_t      point;
    logic        result_valid;
    logic        result_stall;
    result_t     result;
    logic        cfg_wr_en;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_data;

    // Our own copy of the matrix registers, updated alongside each write.
    logic [63:0] matrix_regs [8];

    point_t  pending_points [$];
    result_t expected_results [$];

    int errors;
    int points_sent;
    int results_seen;
    int cycles;
    int wzero_seen;
    int sat_seen;
    bit long_hold;      // when set, the receiver holds stall high for a long stretch

    homogeneous_point_transform_top #(.FRAC_BITS(FB)) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .point_valid  (point_valid),
        .point_stall  (point_stall),
        .point        (point),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Matrix element of row r and column c, sign-extended to 64 bits.
    function automatic longint matrix_elem(input int r, input int c);
        logic [63:0] word;
        word = matrix_regs[r * 2 + c / 2];
        if (c % 2 == 1)
        begin
            return longint'($signed(word[63:32]));
        end
        return longint'($signed(word[31:0]));
    endfunction

    // Scaled divide, truncated toward zero, with saturation to 32 bits.
    function automatic logic [31:0] scaled_quotient(input longint num, input longint den,
                                                    inout bit sat);
        bit        neg;
        logic [63:0] an;
        logic [63:0] ad;
        logic [63:0] ip;
        logic [63:0] rem;
        logic [63:0] mag;
        neg = (num < 0) != (den < 0);
        an  = (num < 0) ? -num : num;
        ad  = (den < 0) ? -den : den;
        ip  = an / ad;
        rem = an % ad;
        if (ip > (64'd1 << (31 - FB)))
        begin
            sat = 1'b1;
            return neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        mag = (ip << FB) + ((rem << FB) / ad);
        if (neg)
        begin
            if (mag > 64'h8000_0000)
            begin
                sat = 1'b1;
                return 32'h8000_0000;
            end
            return 32'(-mag);
        end
        if (mag > 64'h7FFF_FFFF)
        begin
            sat = 1'b1;
            return 32'h7FFF_FFFF;
        end
        return mag[31:0];
    endfunction

    // Works out the transformed point for one input point.
    function automatic result_t transform_point(input point_t p);
        longint  coord [3];
        longint  h [4];
        longint  prod;
        bit      sat;
        result_t r;
        coord[0] = longint'(p.in_x);
        coord[1] = longint'(p.in_y);
        coord[2] = longint'(p.in_z);
        sat = 1'b0;
        for (int c = 0; c < 4; c++)
        begin
            h[c] = matrix_elem(3, c);
            for (int k = 0; k < 3; k++)
            begin
                prod = coord[k] * matrix_elem(k, c);
                h[c] += prod >>> FB;   // arithmetic shift floors toward minus infinity
            end
        end
        if (h[3] == 0)
        begin
            r.out_x  = '0;
            r.out_y  = '0;
            r.out_z  = '0;
            r.status = ST_WZERO;
            return r;
        end
        r.out_x  = scaled_quotient(h[0], h[3], sat);
        r.out_y  = scaled_quotient(h[1], h[3], sat);
        r.out_z  = scaled_quotient(h[2], h[3], sat);
        r.status = sat ? ST_SAT : ST_OK;
        return r;
    endfunction

    function automatic int gap_length();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55)
        begin
            return 0;
        end
        else if (pick < 93)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Random coordinate: mostly moderate values, sometimes any 32-bit pattern.
    function automatic logic [31:0] random_coord();
        if ($urandom_range(0, 3) == 0)
        begin
            return $urandom;
        end
        return 32'($signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000);
    endfunction

    // Random matrix element, mostly between -4.0 and 4.0.
    function automatic logic [31:0] random_elem();
        if ($urandom_range(0, 7) == 0)
        begin
            return $urandom;
        end
        return 32'($signed($urandom_range(0, 32'h0007_FFFF)) - 32'sh0004_0000);
    endfunction

    // Driver: sends pending items, with random gaps, holding each one under stall.
    int send_gap;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_valid <= 1'b0;
            point       <= '0;
            send_gap    <= 0;
            points_sent <= 0;
        end
        else
        begin
            if (point_valid && !point_stall)
            begin
                expected_results.push_back(transform_point(point));
                points_sent <= points_sent + 1;
                if (pending_points.size() > 0 && gap_length() == 0)
                begin
                    point <= pending_points.pop_front();
                end
                else
                begin
                    point_valid <= 1'b0;
                    send_gap    <= gap_length();
                end
            end
            else if (!point_valid)
            begin
                if (send_gap > 0)
                begin
                    send_gap <= send_gap - 1;
                end
                else if (pending_points.size() > 0)
                begin
                    point_valid <= 1'b1;
                    point       <= pending_points.pop_front();
                end
            end
        end
    end

    // Receiver stall pattern: random gaps, plus a long hold on request.
    int stall_left;
    int hold_count;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            stall_left   <= 0;
            hold_count   <= 0;
        end
        else if (long_hold && hold_count < 200)
        begin
            result_stall <= 1'b1;
            hold_count   <= hold_count + 1;
        end
        else if (stall_left > 0)
        begin
            result_stall <= 1'b1;
            stall_left   <= stall_left - 1;
        end
        else
        begin
            stall_left   <= gap_length();
            result_stall <= 1'b0;
            if (!long_hold)
            begin
                hold_count <= 0;
            end
        end
    end

    // Monitor: checks every accepted result against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            results_seen = results_seen + 1;
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, result);
                errors = errors + 1;
            end
            else
            begin
                result_t want;
                want = expected_results.pop_front();
                if (result.status == ST_WZERO) wzero_seen = wzero_seen + 1;
                if (result.status == ST_SAT)   sat_seen   = sat_seen + 1;
                if (result.out_x !== want.out_x)
                begin
                    $display("%0t: out_x expected %h actual %h", $time, want.out_x, result.out_x);
                    errors = errors + 1;
                end
                if (result.out_y !== want.out_y)
                begin
                    $display("%0t: out_y expected %h actual %h", $time, want.out_y, result.out_y);
                    errors = errors + 1;
                end
                if (result.out_z !== want.out_z)
                begin
                    $display("%0t: out_z expected %h actual %h", $time, want.out_z, result.out_z);
                    errors = errors + 1;
                end
                if (result.status !== want.status)
                begin
                    $display("%0t: status expected %0d actual %0d", $time, want.status,
                             result.status);
                    errors = errors + 1;
                end
            end
        end
    end

    // Watchdog: a run that cannot finish is a failure.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Writes one matrix register; only called while nothing is in flight.
    task automatic write_reg(input int index, input logic [63:0] value);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= 3'(index);
        cfg_data  <= value;
        matrix_regs[index] = value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Waits until every queued point has gone in and every result has come out,
    // then lets the pipeline drain for a full latency.
    task automatic wait_idle();
        while (pending_points.size() > 0 || point_valid || expected_results.size() > 0)
        begin
            @(posedge clk);
        end
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic queue_point(input logic [31:0] x, input logic [31:0] y,
                               input logic [31:0] z);
        point_t p;
        p.in_x = x;
        p.in_y = y;
        p.in_z = z;
        pending_points.push_back(p);
    endtask

    // A random matrix, with w kept mostly between one and four so quotients stay in range.
    task automatic load_random_matrix(input bit extremes);
        logic [31:0] e [4][4];
        for (int r = 0; r < 4; r++)
        begin
            for (int c = 0; c < 4; c++)
            begin
                e[r][c] = extremes ? ($urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000)
                                   : random_elem();
            end
        end
        if (!extremes)
        begin
            e[0][3] = $urandom_range(0, 1) ? 32'h0 : 32'($signed($urandom_range(0, 4095)) - 2048);
            e[1][3] = $urandom_range(0, 1) ? 32'h0 : 32'($signed($urandom_range(0, 4095)) - 2048);
            e[2][3] = 32'($signed($urandom_range(0, 8191)) - 4096);
            e[3][3] = 32'h0001_0000 + $urandom_range(0, 32'h0003_0000);
        end
        for (int i = 0; i < 8; i++)
        begin
            write_reg(i, {e[i / 2][(i % 2) * 2 + 1], e[i / 2][(i % 2) * 2]});
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        long_hold    = 1'b0;
        errors       = 0;
        results_seen = 0;
        cycles       = 0;
        wzero_seen   = 0;
        sat_seen     = 0;
        foreach (matrix_regs[i])
        begin
            matrix_regs[i] = CFG_RESET[i];
        end
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed points under the identity matrix left by reset.
        queue_point(32'h0, 32'h0, 32'h0);
        queue_point(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
        queue_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001);
        queue_point(32'h0001_0000, 32'hFFFF_0000, 32'h5555_AAAA);
        wait_idle();

        // Zero w column: every result takes the w-zero path.
        for (int i = 0; i < 8; i++)
        begin
            write_reg(i, 64'h0);
        end
        queue_point(32'h1234_5678, 32'h8000_0000, 32'h7FFF_FFFF);
        queue_point(32'h0, 32'h0, 32'h0);
        wait_idle();

        // Tiny w with large x: quotients overflow in both directions.
        write_reg(0, 64'h0000_0000_7FFF_FFFF);
        write_reg(7, 64'h0000_0001_0000_0000);
        queue_point(32'h7FFF_FFFF, 32'h0, 32'h0);
        queue_point(32'h8000_0000, 32'h0, 32'h0);
        queue_point(32'h0000_0001, 32'h0, 32'h0);
        wait_idle();
        write_reg(7, 64'hFFFF_FFFF_0000_0000);
        queue_point(32'h7FFF_FFFF, 32'h0, 32'h0);
        queue_point(32'h8000_0000, 32'h0, 32'h0);
        wait_idle();

        // Extreme matrix elements throughout.
        load_random_matrix(1'b1);
        for (int i = 0; i < 10; i++)
        begin
            queue_point($urandom, $urandom, $urandom);
        end
        wait_idle();

        // Random phases, each with its own matrix; one phase with a long receiver hold.
        for (int phase = 0; phase < 7; phase++)
        begin
            load_random_matrix(phase == 6);
            for (int i = 0; i < 100; i++)
            begin
                queue_point(random_coord(), random_coord(), random_coord());
            end
            if (phase == 2)
            begin
                long_hold = 1'b1;
            end
            wait_idle();
            long_hold = 1'b0;
        end

        repeat (LATENCY * 2) @(posedge clk);
        $display("Checked %0d results over %0d points and several matrices.",
                 results_seen, points_sent);
        $display("Results with zero w: %0d, with saturation: %0d.", wzero_seen, sat_seen);
        if (errors == 0 && expected_results.size() == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/hpt_pkg.sv
rtl/hpt_mac.sv
rtl/hpt_div.sv
rtl/homogeneous_point_transform_top.sv
rtl/hpt_checker.sv
verif/tb_homogeneous_point_transform_top.sv
